// File: rtl/core/ympr_pkg.sv
// ----------------------------------------------------------------------------
// ympr_pkg
// Shared types, constants and the CRC-16/XMODEM byte step for the receiver.
// ----------------------------------------------------------------------------
package ympr_pkg;

	localparam int DEF_SHORT_PAYLOAD = 128;
	localparam int DEF_LONG_PAYLOAD  = 1024;

	localparam int LEN_W     = 11;
	localparam int CFG_IDX_W = 1;

	// header characters
	localparam logic [7:0] HDR_SOH = 8'h01;
	localparam logic [7:0] HDR_STX = 8'h02;
	localparam logic [7:0] HDR_EOT = 8'h04;
	localparam logic [7:0] HDR_CA  = 8'h18;

	localparam logic [7:0] ABORT_FIRST_RST  = 8'd65;
	localparam logic [7:0] ABORT_SECOND_RST = 8'd97;

	localparam logic [CFG_IDX_W-1:0] REG_ABORT_FIRST  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ABORT_SECOND = 1'd1;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_EOT     = 3'd1;
	localparam logic [2:0] ST_CANCEL  = 3'd2;
	localparam logic [2:0] ST_ABORT   = 3'd3;
	localparam logic [2:0] ST_BADHDR  = 3'd4;
	localparam logic [2:0] ST_SEQERR  = 3'd5;
	localparam logic [2:0] ST_CRCERR  = 3'd6;
	localparam logic [2:0] ST_TIMEOUT = 3'd7;

	localparam logic [15:0] CRC_POLY = 16'h1021;

	typedef struct packed {
		logic             is_status;
		logic [7:0]       payload_byte;
		logic [2:0]       status_code;
		logic [LEN_W-1:0] packet_length;
		logic [7:0]       seq_number;
		logic             ack_req;
		logic             last;
	} res_t;

	function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// File: rtl/core/ympr_fsm.sv
// ----------------------------------------------------------------------------
// ympr_fsm
// Header decode, packet collection and CRC check; one word per step.
// ----------------------------------------------------------------------------
module ympr_fsm
	import ympr_pkg::*;
#(
	parameter int SHORT_PAYLOAD = DEF_SHORT_PAYLOAD,
	parameter int LONG_PAYLOAD  = DEF_LONG_PAYLOAD
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic       cmd,
	input  logic [7:0] rx_byte,
	input  logic [7:0] abort_first,
	input  logic [7:0] abort_second,
	output logic       res_valid,
	output res_t       res
);

	localparam logic [LEN_W-1:0] SHORT_LEN = LEN_W'(SHORT_PAYLOAD);
	localparam logic [LEN_W-1:0] LONG_LEN  = LEN_W'(LONG_PAYLOAD);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_CA2,
		PH_SEQ,
		PH_COMP,
		PH_DATA,
		PH_CRCH,
		PH_CRCL
	} phase_t;

	phase_t           phase_q, phase_d;
	logic             long_q, long_d;
	logic [LEN_W-1:0] count_q, count_d;
	logic [15:0]      crc_q, crc_d;
	logic [7:0]       seq_q, seq_d;
	logic [7:0]       comp_q, comp_d;

	logic [LEN_W-1:0] pkt_len;
	logic [LEN_W-1:0] count_inc;
	logic [15:0]      crc_next;

	assign pkt_len   = long_q ? LONG_LEN : SHORT_LEN;
	assign count_inc = count_q + LEN_W'(1);
	assign crc_next  = crc16_step(crc_q, rx_byte);

	always_comb begin
		phase_d   = phase_q;
		long_d    = long_q;
		count_d   = count_q;
		crc_d     = crc_q;
		seq_d     = seq_q;
		comp_d    = comp_q;
		res_valid = 1'b0;
		res       = '0;
		if (cmd) begin
			res_valid       = 1'b1;
			res.is_status   = 1'b1;
			res.status_code = ST_TIMEOUT;
			res.last        = 1'b1;
			phase_d         = PH_IDLE;
		end else begin
			unique case (phase_q)
				PH_CA2: begin
					res_valid     = 1'b1;
					res.is_status = 1'b1;
					res.last      = 1'b1;
					phase_d       = PH_IDLE;
					if (rx_byte == HDR_CA) begin
						res.status_code = ST_CANCEL;
						res.ack_req     = 1'b1;
					end else begin
						res.status_code = ST_BADHDR;
					end
				end
				PH_SEQ: begin
					seq_d   = rx_byte;
					phase_d = PH_COMP;
				end
				PH_COMP: begin
					comp_d  = rx_byte;
					phase_d = PH_DATA;
				end
				PH_DATA: begin
					crc_d            = crc_next;
					count_d          = count_inc;
					if (count_inc >= pkt_len) begin
						phase_d = PH_CRCH;
					end
					res_valid        = 1'b1;
					res.payload_byte = rx_byte;
				end
				PH_CRCH: begin
					crc_d   = crc_next;
					phase_d = PH_CRCL;
				end
				PH_CRCL: begin
					crc_d          = crc_next;
					res_valid      = 1'b1;
					res.is_status  = 1'b1;
					res.last       = 1'b1;
					res.seq_number = seq_q;
					phase_d        = PH_IDLE;
					if (seq_q != ~comp_q) begin
						res.status_code = ST_SEQERR;
					end else if (crc_next != 16'h0000) begin
						res.status_code = ST_CRCERR;
					end else begin
						res.status_code   = ST_OK;
						res.packet_length = pkt_len;
					end
				end
				default: begin
					phase_d = PH_IDLE;
					if (rx_byte == HDR_SOH || rx_byte == HDR_STX) begin
						long_d  = (rx_byte == HDR_STX);
						count_d = '0;
						crc_d   = '0;
						phase_d = PH_SEQ;
					end else if (rx_byte == HDR_CA) begin
						phase_d = PH_CA2;
					end else begin
						res_valid     = 1'b1;
						res.is_status = 1'b1;
						res.last      = 1'b1;
						if (rx_byte == HDR_EOT) begin
							res.status_code = ST_EOT;
							res.ack_req     = 1'b1;
						end else if (rx_byte == abort_first || rx_byte == abort_second) begin
							res.status_code = ST_ABORT;
						end else begin
							res.status_code = ST_BADHDR;
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			long_q  <= 1'b0;
			count_q <= '0;
			crc_q   <= '0;
			seq_q   <= '0;
			comp_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			long_q  <= long_d;
			count_q <= count_d;
			crc_q   <= crc_d;
			seq_q   <= seq_d;
			comp_q  <= comp_d;
		end
	end

endmodule

// File: rtl/core/ymodem_packet_receiver_unit.sv
// A word accepted on s_axis passes the input register and the result register before it shows on m_axis.
// Throughput: one word per cycle; the input register feeds the decode step and
// the result register, which advance together unless m_axis stalls.
// Words that produce no result (seq, complement, CRC high, SOH/STX, first CA)
// leave m_axis idle. Reset (arst_n low) empties both registers, returns to
// header decode and loads the abort characters with 65 and 97.
// ----------------------------------------------------------------------------
// ymodem_packet_receiver_unit
// YMODEM packet receiver: header decode, payload stream out, CRC-16 check.
// ----------------------------------------------------------------------------
module ymodem_packet_receiver_unit
	import ympr_pkg::*;
#(
	parameter int SHORT_PAYLOAD = DEF_SHORT_PAYLOAD,
	parameter int LONG_PAYLOAD  = DEF_LONG_PAYLOAD
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [7:0]           s_axis_tdata,   // [7:0] rx_byte
	input  logic                 s_axis_tuser,   // [0] cmd
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [31:0]          m_axis_tdata,   // [7:0] payload_byte, [10:8] status_code,
	                                             // [21:11] packet_length, [29:22] seq_number,
	                                             // [30] ack_req, [31] zero
	output logic                 m_axis_tuser,   // [0] is_status
	output logic                 m_axis_tlast    // last
);

	logic       valid_s1;
	logic       cmd_s1;
	logic [7:0] byte_s1;

	logic       out_valid_q;
	res_t       out_q;

	logic [7:0] abort_first_q;
	logic [7:0] abort_second_q;

	logic       adv;
	logic       step;
	logic       res_valid;
	res_t       res;

	assign cfg_ready     = 1'b1;
	assign adv           = !out_valid_q || m_axis_tready;
	assign step          = valid_s1 && adv;
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			abort_first_q  <= ABORT_FIRST_RST;
			abort_second_q <= ABORT_SECOND_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ABORT_FIRST:  abort_first_q  <= cfg_data;
				REG_ABORT_SECOND: abort_second_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			cmd_s1  <= s_axis_tuser;
			byte_s1 <= s_axis_tdata;
		end
	end

	ympr_fsm #(
		.SHORT_PAYLOAD(SHORT_PAYLOAD),
		.LONG_PAYLOAD (LONG_PAYLOAD)
	) u_fsm (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.cmd         (cmd_s1),
		.rx_byte     (byte_s1),
		.abort_first (abort_first_q),
		.abort_second(abort_second_q),
		.res_valid   (res_valid),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && step && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_q.ack_req, out_q.seq_number, out_q.packet_length,
	                        out_q.status_code, out_q.payload_byte};
	assign m_axis_tuser  = out_q.is_status;
	assign m_axis_tlast  = out_q.last;

endmodule

// File: rtl/core/ympr_checker.sv
// ----------------------------------------------------------------------------
// ympr_checker
// Port-level checks on the receiver's result stream.
// ----------------------------------------------------------------------------
module ympr_checker
	import ympr_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic        m_axis_tuser,
	input logic        m_axis_tlast
);

	// stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("m_axis word changed under stall");

	// status words close an event, payload words never do
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast == m_axis_tuser))
		else $error("tlast does not match word kind");

	// payload words carry only the data byte
	a_payload: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[31:8] == 24'h0))
		else $error("payload word carries status fields");

	// only eot and cancel ask for an ack, only ok carries a length
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |->
		(m_axis_tdata[30] == (m_axis_tdata[10:8] == ST_EOT || m_axis_tdata[10:8] == ST_CANCEL))
		&& (m_axis_tdata[10:8] == ST_OK || m_axis_tdata[21:11] == 11'd0)
		&& m_axis_tdata[7:0] == 8'h00)
		else $error("status word fields inconsistent with code");

endmodule

bind ymodem_packet_receiver_unit ympr_checker u_ympr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser),
	.m_axis_tlast (m_axis_tlast)
);

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream testbench for the YMODEM receiver: sends headers, framed packets with
// good or broken sequence and CRC fields, cancels, aborts and timeouts, under
// random gaps and output stalls. Every output word is checked against a
// cycle-free prediction of the receive state machine.
// ----------------------------------------------------------------------------
package ympr_tb_pkg;
	import ympr_pkg::*;

	localparam logic CMD_BYTE    = 1'b0;
	localparam logic CMD_TIMEOUT = 1'b1;

	typedef enum logic [2:0] {
		RX_IDLE,
		RX_CA2,
		RX_SEQ,
		RX_COMP,
		RX_DATA,
		RX_CRC_HI,
		RX_CRC_LO
	} rx_phase_t;

	class packet_scoreboard;
		res_t             pending_results[$];
		int               fail_count;
		int               reported;
		logic [7:0]       abort_first;
		logic [7:0]       abort_second;
		rx_phase_t        rx_phase;
		logic             long_pkt;
		logic [LEN_W-1:0] byte_count;
		logic [15:0]      crc;
		logic [7:0]       seq_byte;
		logic [7:0]       seq_comp;
		int               short_len;
		int               long_len;

		function new(int short_len_i, int long_len_i);
			short_len    = short_len_i;
			long_len     = long_len_i;
			abort_first  = ABORT_FIRST_RST;
			abort_second = ABORT_SECOND_RST;
			rx_phase     = RX_IDLE;
			long_pkt     = 1'b0;
			byte_count   = '0;
			crc          = 16'h0000;
			seq_byte     = 8'h00;
			seq_comp     = 8'h00;
			fail_count   = 0;
			reported     = 0;
		endfunction

		// bit-serial CRC-16/XMODEM, MSB first
		static function logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
			logic fb;
			for (int i = 7; i >= 0; i--) begin
				fb = c[15] ^ b[i];
				c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
			end
			return c;
		endfunction

		function logic [LEN_W-1:0] frame_len();
			return long_pkt ? LEN_W'(long_len) : LEN_W'(short_len);
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
			if (idx == REG_ABORT_FIRST) begin
				abort_first = val;
			end else if (idx == REG_ABORT_SECOND) begin
				abort_second = val;
			end
		endfunction

		function void push_status(logic [2:0] code, logic [LEN_W-1:0] len, logic [7:0] seq,
				logic ack);
			res_t r;
			r.is_status     = 1'b1;
			r.payload_byte  = 8'h00;
			r.status_code   = code;
			r.packet_length = len;
			r.seq_number    = seq;
			r.ack_req       = ack;
			r.last          = 1'b1;
			pending_results.push_back(r);
			rx_phase = RX_IDLE;
		endfunction

		// accepted input word -> expected output words
		function void take_word(logic cmd, logic [7:0] b);
			res_t r;
			if (cmd == CMD_TIMEOUT) begin
				push_status(ST_TIMEOUT, '0, 8'h00, 1'b0);
				return;
			end
			case (rx_phase)
				RX_CA2: begin
					if (b == HDR_CA) begin
						push_status(ST_CANCEL, '0, 8'h00, 1'b1);
					end else begin
						push_status(ST_BADHDR, '0, 8'h00, 1'b0);
					end
				end
				RX_SEQ: begin
					seq_byte = b;
					rx_phase = RX_COMP;
				end
				RX_COMP: begin
					seq_comp = b;
					rx_phase = RX_DATA;
				end
				RX_DATA: begin
					crc        = crc_next(crc, b);
					byte_count = byte_count + 1'b1;
					if (byte_count >= frame_len()) begin
						rx_phase = RX_CRC_HI;
					end
					r              = '0;
					r.payload_byte = b;
					pending_results.push_back(r);
				end
				RX_CRC_HI: begin
					crc      = crc_next(crc, b);
					rx_phase = RX_CRC_LO;
				end
				RX_CRC_LO: begin
					crc = crc_next(crc, b);
					if (seq_byte != ~seq_comp) begin
						push_status(ST_SEQERR, '0, seq_byte, 1'b0);
					end else if (crc != 16'h0000) begin
						push_status(ST_CRCERR, '0, seq_byte, 1'b0);
					end else begin
						push_status(ST_OK, frame_len(), seq_byte, 1'b0);
					end
				end
				default: begin
					// header decode; framing chars win over abort chars
					if (b == HDR_SOH || b == HDR_STX) begin
						long_pkt   = (b == HDR_STX);
						byte_count = '0;
						crc        = 16'h0000;
						rx_phase   = RX_SEQ;
					end else if (b == HDR_EOT) begin
						push_status(ST_EOT, '0, 8'h00, 1'b1);
					end else if (b == HDR_CA) begin
						rx_phase = RX_CA2;
					end else if (b == abort_first || b == abort_second) begin
						push_status(ST_ABORT, '0, 8'h00, 1'b0);
					end else begin
						push_status(ST_BADHDR, '0, 8'h00, 1'b0);
					end
				end
			endcase
		endfunction

		function string fmt(res_t r);
			return $sformatf("st=%0b byte=%02h code=%0d len=%0d seq=%02h ack=%0b last=%0b",
				r.is_status, r.payload_byte, r.status_code, r.packet_length,
				r.seq_number, r.ack_req, r.last);
		endfunction

		function void check_result(res_t got, logic pad);
			res_t want;
			logic bad;
			if (pending_results.size() == 0) begin
				fail_count++;
				if (reported < 10) begin
					reported++;
					$display("[%0t] output word with nothing pending: %s", $time, fmt(got));
				end
				return;
			end
			want = pending_results.pop_front();
			bad  = (got.is_status !== want.is_status) ||
			       (got.payload_byte !== want.payload_byte) ||
			       (got.status_code !== want.status_code) ||
			       (got.packet_length !== want.packet_length) ||
			       (got.seq_number !== want.seq_number) ||
			       (got.ack_req !== want.ack_req) ||
			       (got.last !== want.last) ||
			       (pad !== 1'b0);
			if (bad) begin
				fail_count++;
				if (reported < 10) begin
					reported++;
					$display("[%0t] output word differs", $time);
					$display("  expected %s pad=0", fmt(want));
					$display("  actual   %s pad=%0b", fmt(got), pad);
				end
			end
		endfunction
	endclass

endpackage

module tb_top;
	import ympr_pkg::*;
	import ympr_tb_pkg::*;

	localparam int SHORT_LEN      = DEF_SHORT_PAYLOAD;
	localparam int LONG_LEN       = DEF_LONG_PAYLOAD;
	localparam int HOLD_CYCLES    = 400;
	localparam int SETTLE_CYCLES  = 8;
	localparam int WATCHDOG_LIMIT = 5000;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0]           cfg_data;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [7:0]           s_axis_tdata;
	logic                 s_axis_tuser;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [31:0]          m_axis_tdata;
	logic                 m_axis_tuser;
	logic                 m_axis_tlast;

	packet_scoreboard sb;
	bit               src_gaps;
	bit               sink_stalls;
	bit               hold_req;
	int               words_sent;
	int               idle_cycles;

	ymodem_packet_receiver_unit #(
		.SHORT_PAYLOAD (SHORT_LEN),
		.LONG_PAYLOAD  (LONG_LEN)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic push_word(input logic cmd, input logic [7:0] b);
		int gap;
		gap = src_gaps ? pick_gap() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= b;
		do @(posedge clk); while (!s_axis_tready);
		words_sent++;
	endtask

	task automatic write_regs(input logic [7:0] first, input logic [7:0] second);
		cfg_valid <= 1'b1;
		cfg_index <= REG_ABORT_FIRST;
		cfg_data  <= first;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(REG_ABORT_FIRST, first);
		cfg_index <= REG_ABORT_SECOND;
		cfg_data  <= second;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(REG_ABORT_SECOND, second);
		cfg_valid <= 1'b0;
	endtask

	// drop valid, wait for all pending words, then let no-result words drain
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// header, seq, complement, payload, CRC hi/lo; cut replaces one word after the header by a timeout and ends the packet
	task automatic send_packet(input bit long_pkt, input bit seq_good, input bit crc_good,
			input bit cut);
		logic [7:0]  seq;
		logic [7:0]  comp;
		logic [7:0]  d;
		logic [15:0] crc;
		int          len;
		int          total;
		int          cut_at;
		int          r;
		len    = long_pkt ? LONG_LEN : SHORT_LEN;
		total  = len + 4;
		cut_at = cut ? $urandom_range(0, total - 1) : total;
		seq    = 8'($urandom);
		comp   = seq_good ? ~seq : (~seq ^ 8'($urandom_range(1, 255)));
		crc    = 16'h0000;
		push_word(CMD_BYTE, long_pkt ? HDR_STX : HDR_SOH);
		for (int k = 0; k < total; k++) begin
			if (k == cut_at) begin
				push_word(CMD_TIMEOUT, 8'($urandom));
				return;
			end
			if (k == 0) begin
				d = seq;
			end else if (k == 1) begin
				d = comp;
			end else if (k < len + 2) begin
				r = $urandom_range(0, 19);
				d = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom);
				crc = packet_scoreboard::crc_next(crc, d);
			end else if (k == len + 2) begin
				if (!crc_good) crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
				d = crc[15:8];
			end else begin
				d = crc[7:0];
			end
			push_word(CMD_BYTE, d);
		end
	endtask

	task automatic run_random(input int budget);
		int         stop_at;
		logic [7:0] b;
		stop_at = words_sent + budget;
		while (words_sent < stop_at) begin
			if ($urandom_range(0, 99) < 50) begin
				send_packet(1'b0, $urandom_range(0, 5) != 0,
					$urandom_range(0, 5) != 0, $urandom_range(0, 7) == 0);
			end else begin
				b = 8'($urandom);
				case ($urandom_range(0, 9))
					0: push_word(CMD_BYTE, HDR_EOT);
					1: begin
						push_word(CMD_BYTE, HDR_CA);
						push_word(CMD_BYTE, HDR_CA);
					end
					2: begin
						push_word(CMD_BYTE, HDR_CA);
						push_word(CMD_BYTE, b);
					end
					3: push_word(CMD_BYTE, sb.abort_first);
					4: push_word(CMD_BYTE, sb.abort_second);
					5: push_word(CMD_TIMEOUT, b);
					default: push_word(CMD_BYTE, b);
				endcase
			end
		end
	endtask

	initial begin : sink
		int  hold_left;
		int  run_left;
		bit  run_ready;
		hold_left = 0;
		run_left  = 0;
		run_ready = 1'b0;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (!sink_stalls) begin
				m_axis_tready <= 1'b1;
			end else begin
				if (run_left == 0) begin
					run_ready = !run_ready;
					run_left  = run_ready ? $urandom_range(1, 12) : pick_gap() + 1;
				end
				run_left--;
				m_axis_tready <= run_ready;
			end
		end
	end

	always @(posedge clk) begin : monitor
		res_t got;
		if (s_axis_tvalid && s_axis_tready) begin
			sb.take_word(s_axis_tuser, s_axis_tdata);
		end
		if (m_axis_tvalid && m_axis_tready) begin
			got.is_status     = m_axis_tuser;
			got.payload_byte  = m_axis_tdata[7:0];
			got.status_code   = m_axis_tdata[10:8];
			got.packet_length = m_axis_tdata[21:11];
			got.seq_number    = m_axis_tdata[29:22];
			got.ack_req       = m_axis_tdata[30];
			got.last          = m_axis_tlast;
			sb.check_result(got, m_axis_tdata[31]);
		end
	end

	always @(posedge clk) begin : watchdog
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin : stimulus
		sb            = new(SHORT_LEN, LONG_LEN);
		src_gaps      = 1'b0;
		sink_stalls   = 1'b0;
		hold_req      = 1'b0;
		words_sent    = 0;
		idle_cycles   = 0;
		arst_n        <= 1'b0;
		cfg_valid     <= 1'b0;
		cfg_index     <= REG_ABORT_FIRST;
		cfg_data      <= 8'h00;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= 8'h00;
		s_axis_tuser  <= CMD_BYTE;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// header decode corners with reset abort chars, back to back
		push_word(CMD_TIMEOUT, 8'hFF);
		push_word(CMD_BYTE, HDR_EOT);
		push_word(CMD_BYTE, HDR_CA);
		push_word(CMD_BYTE, HDR_CA);
		push_word(CMD_BYTE, HDR_CA);
		push_word(CMD_BYTE, 8'h00);
		push_word(CMD_BYTE, ABORT_FIRST_RST);
		push_word(CMD_BYTE, ABORT_SECOND_RST);
		push_word(CMD_BYTE, 8'h00);
		push_word(CMD_BYTE, 8'hFF);
		push_word(CMD_BYTE, 8'h03);
		push_word(CMD_BYTE, HDR_CA);
		push_word(CMD_TIMEOUT, 8'h00);
		push_word(CMD_BYTE, HDR_SOH);
		push_word(CMD_BYTE, 8'h00);
		push_word(CMD_TIMEOUT, 8'h55);
		push_word(CMD_BYTE, HDR_STX);
		push_word(CMD_BYTE, 8'hFF);
		push_word(CMD_BYTE, 8'h00);
		push_word(CMD_BYTE, 8'hAA);
		push_word(CMD_TIMEOUT, 8'hAA);

		src_gaps    = 1'b1;
		sink_stalls = 1'b1;
		// seq and CRC both broken
		send_packet(1'b0, 1'b0, 1'b0, 1'b0);
		run_random(150);
		settle();

		// extremes; sink holds off while source offers a full packet without gaps
		write_regs(8'h00, 8'hFF);
		hold_req = 1'b1;
		src_gaps = 1'b0;
		send_packet(1'b0, 1'b1, 1'b1, 1'b0);
		src_gaps = 1'b1;
		run_random(100);
		settle();

		// abort chars shadowed by framing chars
		write_regs(HDR_SOH, HDR_CA);
		run_random(80);
		settle();

		write_regs(8'($urandom), 8'($urandom));
		run_random(120);
		settle();

		write_regs(8'hFF, 8'h00);
		src_gaps    = 1'b0;
		sink_stalls = 1'b0;
		run_random(80);
		settle();

		if (sb.fail_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
